[rtl/table_shift_add_string_hash_assert.svh]
// ----------------------------------------------------------------------------
// String hash assertion macros
// Shared assertion forms for the string hash block.
// ----------------------------------------------------------------------------
`ifndef TABLE_SHIFT_ADD_STRING_HASH_ASSERT_SVH
`define TABLE_SHIFT_ADD_STRING_HASH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSAH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("string hash: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSAH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("string hash: next-cycle check failed");

`endif

[rtl/tsah_pkg.sv]
// ----------------------------------------------------------------------------
// String hash package
// Widths, constants, the byte weight table and the job word type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tsah_pkg;

   localparam int BYTE_WIDTH   = 8;
   localparam int WEIGHT_WIDTH = 16;
   localparam int HASH_WIDTH   = 32;
   localparam int COUNT_WIDTH  = 31;
   localparam int SHIFT_STEP   = 2;

   localparam logic [HASH_WIDTH-1:0]  HASH_START  = 32'd1;
   localparam logic [COUNT_WIDTH-1:0] COUNT_RESET = 31'd1;

   localparam int DEF_MAX_KEY_CHARS = 16;
   localparam int DEF_FIFO_DEPTH    = 4;

   // Per-byte weights added into the accumulator.
   localparam logic [WEIGHT_WIDTH-1:0] BYTE_WEIGHT [256] = '{
      16'd55927, 16'd27986, 16'd22456, 16'd45590, 16'd1689, 16'd59121, 16'd18631,
      16'd63603, 16'd40390, 16'd56613, 16'd62650, 16'd8113, 16'd2737, 16'd11977,
      16'd61089, 16'd58842, 16'd2410, 16'd61547, 16'd41563, 16'd2425, 16'd20424,
      16'd37079, 16'd57177, 16'd43580, 16'd2818, 16'd31807, 16'd3450, 16'd55588,
      16'd25693, 16'd34820, 16'd36374, 16'd45670, 16'd24319, 16'd4387, 16'd60183,
      16'd64226, 16'd32995, 16'd22335, 16'd38465, 16'd56125, 16'd55526, 16'd15942,
      16'd6802, 16'd62109, 16'd5118, 16'd16579, 16'd49603, 16'd39680, 16'd29578,
      16'd64704, 16'd53231, 16'd55609, 16'd38595, 16'd25942, 16'd38731, 16'd4745,
      16'd10578, 16'd17107, 16'd50707, 16'd16854, 16'd43260, 16'd19334, 16'd28806,
      16'd1674, 16'd38008, 16'd48937, 16'd30983, 16'd34571, 16'd30050, 16'd3819,
      16'd6245, 16'd49362, 16'd22343, 16'd48154, 16'd26676, 16'd32810, 16'd24032,
      16'd14186, 16'd61786, 16'd55688, 16'd19548, 16'd10980, 16'd24742, 16'd40577,
      16'd61398, 16'd14446, 16'd41882, 16'd59500, 16'd32486, 16'd55027, 16'd53065,
      16'd29332, 16'd8275, 16'd38959, 16'd21339, 16'd7706, 16'd60134, 16'd49432,
      16'd6958, 16'd39270, 16'd53338, 16'd48876, 16'd24343, 16'd50503, 16'd1391,
      16'd41684, 16'd1990, 16'd4527, 16'd39197, 16'd28210, 16'd42439, 16'd44036,
      16'd3302, 16'd39308, 16'd7973, 16'd63780, 16'd57413, 16'd57364, 16'd21801,
      16'd29944, 16'd8514, 16'd63955, 16'd9280, 16'd45491, 16'd13351, 16'd36466,
      16'd16378, 16'd53416, 16'd9293, 16'd19109, 16'd36143, 16'd28358, 16'd61455,
      16'd41524, 16'd48188, 16'd40625, 16'd25056, 16'd26791, 16'd1387, 16'd10877,
      16'd10361, 16'd2702, 16'd2417, 16'd63241, 16'd42, 16'd53610, 16'd63504,
      16'd758, 16'd57170, 16'd15420, 16'd16093, 16'd6979, 16'd14314, 16'd5799,
      16'd8732, 16'd65415, 16'd32827, 16'd39108, 16'd49607, 16'd20425, 16'd21680,
      16'd31107, 16'd11438, 16'd15871, 16'd42182, 16'd32184, 16'd17336, 16'd40226,
      16'd32031, 16'd44490, 16'd20295, 16'd34794, 16'd8374, 16'd64499, 16'd18618,
      16'd31019, 16'd17198, 16'd50484, 16'd64011, 16'd20428, 16'd22083, 16'd14041,
      16'd13721, 16'd22623, 16'd64609, 16'd17060, 16'd34817, 16'd5730, 16'd53843,
      16'd27545, 16'd58917, 16'd10002, 16'd57876, 16'd21861, 16'd63822, 16'd14310,
      16'd12482, 16'd41068, 16'd52078, 16'd43695, 16'd63920, 16'd15470, 16'd46462,
      16'd8522, 16'd18586, 16'd64469, 16'd37382, 16'd51966, 16'd50419, 16'd53661,
      16'd21947, 16'd60793, 16'd41051, 16'd50144, 16'd20546, 16'd50018, 16'd47661,
      16'd15613, 16'd30483, 16'd27290, 16'd10804, 16'd1380, 16'd15481, 16'd15381,
      16'd33917, 16'd53249, 16'd38069, 16'd34638, 16'd18503, 16'd58179, 16'd60226,
      16'd19308, 16'd3095, 16'd2248, 16'd59956, 16'd10223, 16'd6376, 16'd36263,
      16'd5562, 16'd24342, 16'd18048, 16'd48473, 16'd24002, 16'd25553, 16'd2782,
      16'd57668, 16'd59323, 16'd3422, 16'd52944, 16'd28390, 16'd29302, 16'd10883,
      16'd47521, 16'd44699, 16'd54822, 16'd52838
   };

   // One finished key handed from the front end to the back end.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] bucket_count;
      logic [HASH_WIDTH-1:0]  hash;
   } job_type;

endpackage

`default_nettype wire

[rtl/tsah_front.sv]
// ----------------------------------------------------------------------------
// String hash front end
// Takes key bytes, accumulates the hash and queues a job at each key end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsah_front #(
   parameter int MAX_KEY_CHARS = tsah_pkg::DEF_MAX_KEY_CHARS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [tsah_pkg::BYTE_WIDTH-1:0]  req_key_byte,
   input  wire logic                            req_push,
   output      logic                            req_full,
   input  wire logic                            csr_wr_en,
   input  wire logic [tsah_pkg::COUNT_WIDTH-1:0] csr_wr_data,
   output      logic                            job_push,
   output      tsah_pkg::job_type               job_word,
   input  wire logic                            job_full
);
   import tsah_pkg::*;

   localparam int CNT_W = $clog2(MAX_KEY_CHARS + 1);

   logic [HASH_WIDTH-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [COUNT_WIDTH-1:0] bucket_count_ff;
   logic                   take;
   logic                   key_end;

   // A word is taken whenever the job queue has room.
   assign req_full = job_full;
   assign take     = req_push && !job_full;
   assign key_end  = (req_key_byte == '0);

   // The key end pushes the finished hash together with the bucket count.
   assign job_push              = take && key_end;
   assign job_word.hash         = acc_ff;
   assign job_word.bucket_count = bucket_count_ff;

   // Shift-add step for the first bytes of a key; restart at the key end.
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (take) begin
         if (key_end) begin
            acc_in = HASH_START;
            cnt_in = '0;
         end else if (cnt_ff < CNT_W'(MAX_KEY_CHARS)) begin
            acc_in = (acc_ff << SHIFT_STEP) + HASH_WIDTH'(BYTE_WEIGHT[req_key_byte]);
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= HASH_START;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

   // Bucket count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= COUNT_RESET;
      end else if (csr_wr_en) begin
         bucket_count_ff <= csr_wr_data;
      end
   end

endmodule

`default_nettype wire

[rtl/tsah_fifo.sv]
// ----------------------------------------------------------------------------
// String hash job queue
// Short queue of finished keys between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tsah_fifo #(
   parameter int DEPTH = tsah_pkg::DEF_FIFO_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire tsah_pkg::job_type push_word,
   output      logic              full,
   input  wire logic              pop,
   output      tsah_pkg::job_type pop_word,
   output      logic              empty
);
   import tsah_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

   // Pointers wrap at the depth; the count tracks occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/tsah_back.sv]
// ----------------------------------------------------------------------------
// String hash back end
// Restoring remainder unit, one dividend bit per cycle bar result word stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "table_shift_add_string_hash_assert.svh"

module tsah_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire tsah_pkg::job_type               job_word,
   input  wire logic                            job_empty,
   output      logic                            job_pop,
   output      logic                            rsp_empty,
   input  wire logic                            rsp_pop,
   output      logic [tsah_pkg::COUNT_WIDTH-1:0] rsp_bucket_index,
   output      logic [tsah_pkg::HASH_WIDTH-1:0]  rsp_hash_value
);
   import tsah_pkg::*;

   localparam int                STEP_W    = $clog2(HASH_WIDTH);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HASH_WIDTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type              state_ff, state_in;
   logic [STEP_W-1:0]      step_ff;
   logic [COUNT_WIDTH-1:0] div_ff;
   logic [COUNT_WIDTH-1:0] rem_ff, rem_next;
   logic [HASH_WIDTH-1:0]  dvd_ff;
   logic [HASH_WIDTH-1:0]  hash_ff;
   logic [HASH_WIDTH-1:0]  rem_shift, rem_diff;
   logic                   out_valid_ff;
   logic                   out_take, out_load, last_step;

   // One restoring step: bring in the next dividend bit, subtract if it fits.
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[HASH_WIDTH-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      if (rem_shift >= {1'b0, div_ff}) begin
         rem_next = rem_diff[COUNT_WIDTH-1:0];
      end else begin
         rem_next = rem_shift[COUNT_WIDTH-1:0];
      end
   end

   assign last_step = (state_ff == ST_RUN) && (step_ff == STEP_LAST);
   assign out_take  = rsp_pop && out_valid_ff;
   assign out_load  = last_step && (!out_valid_ff || out_take);
   assign job_pop   = (state_ff == ST_IDLE) && !job_empty;
   assign rsp_empty = !out_valid_ff;

   // Sequencer: load a job, run the steps, hold the last one until the
   // result word is free.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!job_empty) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath of the remainder unit.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         div_ff  <= job_word.bucket_count;
         dvd_ff  <= job_word.hash;
         hash_ff <= job_word.hash;
         rem_ff  <= '0;
         step_ff <= '0;
      end else if ((state_ff == ST_RUN) && !last_step) begin
         rem_ff  <= rem_next;
         dvd_ff  <= dvd_ff << 1;
         step_ff <= step_ff + 1'b1;
      end
   end

   // Result word; a zero bucket count gives index zero.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_bucket_index <= (div_ff == '0) ? '0 : rem_next;
         rsp_hash_value   <= hash_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // The partial remainder always stays below a nonzero divisor.
   `TSAH_ASSERT_SAME(a_rem_below_div, clock, reset,
      (state_ff == ST_RUN) && (div_ff != '0), rem_ff < div_ff)
   // A job is only taken while the unit is free.
   `TSAH_ASSERT_SAME(a_pop_when_idle, clock, reset, job_pop, state_ff == ST_IDLE)
   // Finishing the last step always leaves a result word waiting.
   `TSAH_ASSERT_NEXT(a_load_gives_word, clock, reset, out_load,
      out_valid_ff && (state_ff == ST_IDLE))

endmodule

`default_nettype wire

[rtl/table_shift_add_string_hash.sv]
// Key bytes enter at one per cycle while req_full is low, and a zero byte
// closes the key. Each key yields one word holding the raw hash and the hash
// modulo the bucket count. The front end never stalls a key's bytes while the
// job queue has room (FIFO_DEPTH finished keys). The back end's bit-serial
// remainder unit loads a finished key, then takes one dividend bit per cycle,
// holding the last while the result word is full; it takes no new key before
// the last is done, so short keys back up into req_full once the queue fills.
// A finished word waits in its own register while the next key runs up to its
// last bit. Each key uses the bucket count written before its zero byte.
// ----------------------------------------------------------------------------
// String hash top level
// Table-driven shift-add string hash with a bucket index per key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module table_shift_add_string_hash #(
   parameter int MAX_KEY_CHARS = tsah_pkg::DEF_MAX_KEY_CHARS,
   parameter int FIFO_DEPTH    = tsah_pkg::DEF_FIFO_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [tsah_pkg::BYTE_WIDTH-1:0]  req_key_byte,
   input  wire logic                            req_push,
   output      logic                            req_full,
   output      logic                            rsp_empty,
   input  wire logic                            rsp_pop,
   output      logic [tsah_pkg::COUNT_WIDTH-1:0] rsp_bucket_index,
   output      logic [tsah_pkg::HASH_WIDTH-1:0]  rsp_hash_value,
   input  wire logic                            csr_wr_en,
   input  wire logic [tsah_pkg::COUNT_WIDTH-1:0] csr_wr_data
);
   import tsah_pkg::*;

   logic    job_push, job_full, job_pop, job_empty;
   job_type job_in_word, job_out_word;

   // Byte intake and hash accumulation.
   tsah_front #(
      .MAX_KEY_CHARS (MAX_KEY_CHARS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_key_byte (req_key_byte),
      .req_push     (req_push),
      .req_full     (req_full),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .job_push     (job_push),
      .job_word     (job_in_word),
      .job_full     (job_full)
   );

   // Finished keys waiting for the remainder unit.
   tsah_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_word (job_in_word),
      .full      (job_full),
      .pop       (job_pop),
      .pop_word  (job_out_word),
      .empty     (job_empty)
   );

   // Bucket index computation and result word.
   tsah_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_word         (job_out_word),
      .job_empty        (job_empty),
      .job_pop          (job_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_hash_value   (rsp_hash_value)
   );

endmodule

`default_nettype wire
